// ===== hw/rtl/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants for the counting sort engine.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int KEY_BITS_DEF = 8;   // default key width used for the histogram
    localparam int CAPACITY_DEF = 64;  // default keys kept per set
    localparam int IN_KEY_W     = 8;   // key field on the input stream
    localparam int OUT_KEY_W    = 8;   // key field on the output stream
    localparam int QUEUE_DEPTH  = 4;   // front-to-back queue, power of two

    // per-request control travelling through the queue
    typedef struct packed {
        logic inc;   // key is counted
        logic last;  // final key of the set
        logic drop;  // some key of the set was dropped so far
    } t_q_flags;

    localparam int FLAGS_W = $bits(t_q_flags);

endpackage

// ===== hw/rtl/cse_front.sv =====
// ----------------------------------------------------------------------------
// cse_front
// Accepts keys, checks them against set capacity and tags each request.
// ----------------------------------------------------------------------------
module cse_front #(
    parameter int KEY_BITS = cse_pkg::KEY_BITS_DEF,
    parameter int CAPACITY = cse_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [cse_pkg::IN_KEY_W-1:0]  i_s_tdata,   // [7:0] key
    input  logic                          i_s_tlast,   // last_key
    input  logic                          i_init_done,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output logic [KEY_BITS-1:0]           o_q_key,
    output logic [$clog2(CAPACITY+1)-1:0] o_q_total,
    output cse_pkg::t_q_flags             o_q_flags
);
    import cse_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_count;
    logic          r_drop;
    logic          counted;
    logic [CW-1:0] cnt_inc;

    assign o_s_tready = i_init_done && !i_q_full;
    assign o_q_push   = i_s_tvalid && o_s_tready;

    assign counted = r_count < CW'(CAPACITY);
    assign cnt_inc = r_count + CW'(1);

    assign o_q_key        = KEY_BITS'(i_s_tdata);
    assign o_q_total      = counted ? cnt_inc : r_count;
    assign o_q_flags.inc  = counted;
    assign o_q_flags.last = i_s_tlast;
    assign o_q_flags.drop = r_drop || !counted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (o_q_push) begin
            if (i_s_tlast) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end else begin
                r_count <= o_q_total;
                r_drop  <= o_q_flags.drop;
            end
        end
    end

endmodule

// ===== hw/rtl/cse_queue.sv =====
// ----------------------------------------------------------------------------
// cse_queue
// Short register FIFO between the front and the histogram back end.
// ----------------------------------------------------------------------------
module cse_queue #(
    parameter int W     = 8,
    parameter int DEPTH = cse_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_vld,
    output logic [W-1:0] o_data
);
    import cse_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    assign o_full = r_cnt == (AW+1)'(DEPTH);
    assign o_vld  = r_cnt != '0;
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/cse_back.sv =====
// ----------------------------------------------------------------------------
// cse_back
// Histogram RAM: clearing pass, count updates, ascending drain walk.
// ----------------------------------------------------------------------------
module cse_back #(
    parameter int KEY_BITS = cse_pkg::KEY_BITS_DEF,
    parameter int CAPACITY = cse_pkg::CAPACITY_DEF,
    parameter int QW       = cse_pkg::FLAGS_W + KEY_BITS + $clog2(CAPACITY+1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_vld,
    input  logic [QW-1:0]                 i_q_data,
    output logic                          o_q_pop,
    output logic                          o_init_done,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [cse_pkg::OUT_KEY_W-1:0] o_m_tdata,   // [7:0] sorted_key
    output logic                          o_m_tlast,   // last_out
    output logic                          o_m_tuser    // overflow
);
    import cse_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int DEPTH = 1 << KEY_BITS;

    typedef enum logic [2:0] {
        S_CLR,
        S_LOAD,
        S_RD,
        S_CHK,
        S_EMIT
    } t_state;

    logic [CW-1:0]       r_hist [DEPTH];
    logic [CW-1:0]       r_rd_data;

    t_state              r_state;
    logic [KEY_BITS-1:0] r_k;
    logic                r_s1_vld;
    logic [KEY_BITS-1:0] r_s1_key;
    logic [CW-1:0]       r_s1_total;
    t_q_flags            r_s1_flags;
    logic                r_fw_vld;
    logic [KEY_BITS-1:0] r_fw_key;
    logic [CW-1:0]       r_fw_val;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_emitted;
    logic [CW-1:0]       r_total;
    logic                r_ovf;
    logic                r_out_vld;
    logic [OUT_KEY_W-1:0] r_out_key;
    logic                r_out_last;
    logic                r_out_ovf;

    t_q_flags            q_flags;
    logic [KEY_BITS-1:0] q_key;
    logic [CW-1:0]       q_total;
    logic [CW-1:0]       base;
    logic [CW-1:0]       upd;
    logic                out_free;
    logic [CW-1:0]       emitted_nx;
    logic                fin;
    logic [KEY_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [KEY_BITS-1:0] wr_addr;
    logic [CW-1:0]       wr_data;

    assign q_flags = t_q_flags'(i_q_data[FLAGS_W-1:0]);
    assign q_key   = i_q_data[FLAGS_W +: KEY_BITS];
    assign q_total = i_q_data[FLAGS_W+KEY_BITS +: CW];

    // hold popping once the last key of a set sits in the update stage
    assign o_q_pop = (r_state == S_LOAD) && i_q_vld && !(r_s1_vld && r_s1_flags.last);

    // same key written on the previous edge: RAM read is stale
    assign base = (r_fw_vld && (r_fw_key == r_s1_key)) ? r_fw_val : r_rd_data;
    assign upd  = base + CW'(1);

    assign out_free   = !r_out_vld || i_m_tready;
    assign emitted_nx = r_emitted + CW'(1);
    assign fin        = emitted_nx == r_total;

    always_comb begin
        case (r_state)
            S_LOAD:  rd_addr = q_key;
            S_RD:    rd_addr = r_k;
            default: rd_addr = r_k + KEY_BITS'(1);
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_k;
        wr_data = '0;
        case (r_state)
            S_CLR: begin
                wr_en = 1'b1;
            end
            S_LOAD: begin
                wr_en   = r_s1_vld && r_s1_flags.inc;
                wr_addr = r_s1_key;
                wr_data = upd;
            end
            S_CHK: begin
                // clear on read during the walk
                wr_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[wr_addr] <= wr_data;
        end
        r_rd_data <= r_hist[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_fw_key <= wr_addr;
        r_fw_val <= wr_data;
        if (o_q_pop) begin
            r_s1_key   <= q_key;
            r_s1_total <= q_total;
            r_s1_flags <= q_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_k       <= '0;
            r_s1_vld  <= 1'b0;
            r_fw_vld  <= 1'b0;
            r_emitted <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld <= o_q_pop;
            r_fw_vld <= wr_en;
            if ((r_state == S_EMIT) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_k <= r_k + KEY_BITS'(1);
                    if (r_k == '1) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_s1_vld && r_s1_flags.last) begin
                        r_state   <= S_RD;
                        r_k       <= '0;
                        r_total   <= r_s1_total;
                        r_ovf     <= r_s1_flags.drop;
                        r_emitted <= '0;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_rd_data == '0) begin
                        r_k <= r_k + KEY_BITS'(1);
                    end else begin
                        r_cnt   <= r_rd_data;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_key  <= OUT_KEY_W'(r_k);
                        r_out_last <= fin;
                        r_out_ovf  <= r_ovf;
                        r_cnt      <= r_cnt - CW'(1);
                        r_emitted  <= emitted_nx;
                        if (fin) begin
                            r_state <= S_LOAD;
                        end else if (r_cnt == CW'(1)) begin
                            r_k     <= r_k + KEY_BITS'(1);
                            r_state <= S_CHK;
                        end
                    end
                end
                default: begin
                    r_state <= S_CLR;
                end
            endcase
        end
    end

    assign o_init_done = r_state != S_CLR;
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = r_out_key;
    assign o_m_tlast   = r_out_last;
    assign o_m_tuser   = r_out_ovf;

`ifndef NO_ASSERTIONS
    a_s1_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_state == S_LOAD))
        else $error("update stage busy outside load phase");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt != '0))
        else $error("emitting from an empty histogram entry");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CHK) || (r_state == S_EMIT)) |-> (r_emitted < r_total))
        else $error("drain walk ran past the set size");

    a_no_pop_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_q_pop)
        else $error("queue popped during clearing pass");
`endif

endmodule

// ===== hw/rtl/counting_sort_engine_unit.sv =====
// ----------------------------------------------------------------------------
// counting_sort_engine_unit
// Counting sort of unsigned keys through a histogram RAM.
//
//   channel  dir  tdata            tlast     tuser
//   s        in   [7:0] key        last_key  -
//   m        out  [7:0] sorted_key last_out  overflow
//
// After reset a clearing pass zeroes the histogram with o_s_tready low. Keys
// then load one per cycle, while the back end is in its load phase, through
// a 4-deep queue into a read-modify-write pipeline on the histogram RAM. The
// last key of a set starts the drain walk: a read state, then a check of each
// key value in turn up to the highest key present, with an emit step per
// result. Up to 4 keys of the next set queue during the walk; a stalled
// output holds the walk.
// ----------------------------------------------------------------------------
module counting_sort_engine_unit #(
    parameter int KEY_BITS = cse_pkg::KEY_BITS_DEF,
    parameter int CAPACITY = cse_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [cse_pkg::IN_KEY_W-1:0]  i_s_tdata,   // [7:0] key
    input  logic                          i_s_tlast,   // last_key
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [cse_pkg::OUT_KEY_W-1:0] o_m_tdata,   // [7:0] sorted_key
    output logic                          o_m_tlast,   // last_out
    output logic                          o_m_tuser    // overflow
);
    import cse_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int QW = FLAGS_W + KEY_BITS + CW;

    logic                init_done;
    logic                q_full;
    logic                q_push;
    logic [KEY_BITS-1:0] q_key;
    logic [CW-1:0]       q_total;
    t_q_flags            q_flags;
    logic                q_pop;
    logic                q_vld;
    logic [QW-1:0]       q_out;

    cse_front #(
        .KEY_BITS (KEY_BITS),
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_init_done (init_done),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_key     (q_key),
        .o_q_total   (q_total),
        .o_q_flags   (q_flags)
    );

    cse_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({q_total, q_key, q_flags}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_data  (q_out)
    );

    cse_back #(
        .KEY_BITS (KEY_BITS),
        .CAPACITY (CAPACITY),
        .QW       (QW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (q_vld),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .o_init_done (init_done),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

// ===== sim/counting_sort_engine_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// counting_sort_engine_unit_test
// Self-checking bench for the counting sort engine. A queue of key requests,
// grouped into sets closed by tlast, feeds a stream driver. Each accepted key
// is tallied into a local histogram. A closing key expands the histogram into
// the sorted run that the output stream must match. Directed sets cover the
// edge keys, all-zero sets and duplicates. Random sets include full and
// overflowing ones. The run steps through several sender and receiver
// idling mixes.
// ----------------------------------------------------------------------------
module counting_sort_engine_unit_test;

    localparam int KEY_RANGE = 1 << cse_pkg::KEY_BITS_DEF;
    localparam int CAPACITY  = cse_pkg::CAPACITY_DEF;

    typedef struct packed {
        logic [cse_pkg::IN_KEY_W-1:0] key;
        logic                         last;
    } t_key_req;

    typedef struct packed {
        logic [cse_pkg::OUT_KEY_W-1:0] key;
        logic                          last;
        logic                          ovf;
    } t_sorted_res;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [cse_pkg::IN_KEY_W-1:0]  i_s_tdata  = '0;   // [7:0] key
    logic                          i_s_tlast  = 1'b0; // last_key
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [cse_pkg::OUT_KEY_W-1:0] o_m_tdata;         // [7:0] sorted_key
    logic                          o_m_tlast;         // last_out
    logic                          o_m_tuser;         // overflow

    t_key_req    key_reqs_q[$];
    t_sorted_res sorted_run_q[$];

    // local copy of the histogram and per-set bookkeeping
    logic [6:0] tally_hist[KEY_RANGE];
    int         tally_count   = 0;
    logic       tally_dropped = 1'b0;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int n_errors        = 0;
    int n_keys_sent     = 0;
    int n_sets_sorted   = 0;
    int n_overflow_sets = 0;
    int n_results_seen  = 0;

    counting_sort_engine_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        foreach (tally_hist[k]) tally_hist[k] = '0;
    end

    // count one accepted key; a closing key turns the histogram into the run
    task automatic tally_key(input logic [cse_pkg::IN_KEY_W-1:0] key, input logic last_key);
        t_sorted_res r;
        int emitted;
        if (tally_count < CAPACITY) begin
            tally_hist[key] = tally_hist[key] + 7'd1;
            tally_count++;
        end else begin
            tally_dropped = 1'b1;
        end
        if (last_key) begin
            emitted = 0;
            for (int k = 0; k < KEY_RANGE; k++) begin
                for (int n = 0; n < tally_hist[k]; n++) begin
                    r.key  = k[cse_pkg::OUT_KEY_W-1:0];
                    r.last = (emitted + 1 == tally_count);
                    r.ovf  = tally_dropped;
                    sorted_run_q.push_back(r);
                    emitted++;
                end
                tally_hist[k] = '0;
            end
            n_sets_sorted++;
            if (tally_dropped) n_overflow_sets++;
            tally_count   = 0;
            tally_dropped = 1'b0;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_key_req req;
        if (i_s_tvalid && o_s_tready) begin
            tally_key(i_s_tdata, i_s_tlast);
            n_keys_sent++;
        end
        if (!i_s_tvalid || o_s_tready) begin
            if (i_rst_n && key_reqs_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                req = key_reqs_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= req.key;
                i_s_tlast  <= req.last;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_sorted_res exp_r;
        if (o_m_tvalid && i_m_tready) begin
            n_results_seen++;
            if (sorted_run_q.size() == 0) begin
                $error("unexpected result: sorted_key %0d last_out %0d overflow %0d",
                       o_m_tdata, o_m_tlast, o_m_tuser);
                n_errors++;
            end else begin
                exp_r = sorted_run_q.pop_front();
                if (o_m_tdata !== exp_r.key) begin
                    $error("sorted_key mismatch: expected %0d, actual %0d", exp_r.key, o_m_tdata);
                    n_errors++;
                end
                if (o_m_tlast !== exp_r.last) begin
                    $error("last_out mismatch: expected %0d, actual %0d", exp_r.last, o_m_tlast);
                    n_errors++;
                end
                if (o_m_tuser !== exp_r.ovf) begin
                    $error("overflow mismatch: expected %0d, actual %0d", exp_r.ovf, o_m_tuser);
                    n_errors++;
                end
            end
        end
        i_m_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic push_key(input int key, input bit last_key);
        t_key_req req;
        req.key  = key[cse_pkg::IN_KEY_W-1:0];
        req.last = last_key;
        key_reqs_q.push_back(req);
    endtask

    // random set; narrow keys give plenty of duplicates, long sets fill or overflow
    task automatic push_random_set(output int len);
        bit narrow;
        int lo;
        narrow = ($urandom_range(2) == 0);
        lo     = $urandom_range(KEY_RANGE - 8);
        if ($urandom_range(11) == 0)
            len = $urandom_range(CAPACITY + 8, CAPACITY);
        else
            len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++)
            push_key(narrow ? lo + $urandom_range(7) : $urandom_range(KEY_RANGE - 1),
                     i == len - 1);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (key_reqs_q.size() != 0 || i_s_tvalid || sorted_run_q.size() != 0);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_keys);
        int added;
        int len;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        added = 0;
        while (added < n_keys) begin
            push_random_set(len);
            added += len;
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: edge keys alone, all-zero set, duplicates, mixed extremes
        push_key(0, 1);
        push_key(KEY_RANGE - 1, 1);
        for (int i = 0; i < 4; i++) push_key(0, i == 3);
        for (int i = 0; i < 3; i++) push_key(7, i == 2);
        push_key(KEY_RANGE - 1, 0);
        push_key(0, 0);
        push_key(8'h80, 0);
        push_key(1, 0);
        push_key(0, 0);
        push_key(8'h55, 0);
        push_key(8'hAA, 0);
        push_key(KEY_RANGE - 1, 1);
        push_key(8'h7F, 0);
        push_key(8'hFE, 0);
        push_key(8'h01, 1);
        wait_drained();

        // a full set, then one whose closing key is dropped
        for (int i = 0; i < CAPACITY; i++)
            push_key($urandom_range(KEY_RANGE - 1), i == CAPACITY - 1);
        for (int i = 0; i <= CAPACITY; i++)
            push_key($urandom_range(KEY_RANGE - 1), i == CAPACITY);
        wait_drained();

        run_phase(0, 0, 20);
        run_phase(63, 0, 20);
        run_phase(0, 63, 20);
        run_phase(13, 13, 20);

        repeat (400) @(posedge i_clk);
        $display("%0d keys in %0d sets sorted, %0d with dropped keys; %0d results checked",
                 n_keys_sent, n_sets_sorted, n_overflow_sets, n_results_seen);
        if (n_errors == 0 && sorted_run_q.size() == 0) begin
            $display("counting_sort_engine_unit_test passed");
        end else begin
            $display("counting_sort_engine_unit_test failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout: %0d results still outstanding", sorted_run_q.size());
        $display("counting_sort_engine_unit_test failed");
        $finish;
    end

endmodule
